/* design/apc_pkg.sv */
// Shared types, constants and a helper function of the averaged piecewise calibration unit.
`timescale 1ns / 1ps

package apc_pkg;

    // Field widths of the item and result transfers.
    localparam int SAMPLE_W   = 16;
    localparam int CHAN_W     = 3;
    localparam int POINT_W    = 2;
    localparam int POINTS     = 4;

    // Width of a segment quotient: the offset inside one quarter of full scale.
    localparam int FRAC_W     = 14;

    // Configuration port.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_AVG_ON = 2'd0;

    // Item kinds.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    // Output quarter points.
    localparam logic [SAMPLE_W-1:0] QUARTER_1  = 16'd16384;
    localparam logic [SAMPLE_W-1:0] QUARTER_2  = 16'd32768;
    localparam logic [SAMPLE_W-1:0] QUARTER_3  = 16'd49152;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd65535;

    // Last step of the fetch sequence (four breakpoint reads plus one drain step).
    localparam logic [2:0] FETCH_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MEAN,
        ST_SELECT,
        ST_SEG,
        ST_OUT
    } apc_state_t;

    typedef enum logic {
        DIV_MEAN,
        DIV_SEGMENT
    } apc_div_kind_t;

    typedef struct packed {
        logic          start;
        apc_div_kind_t kind;
    } apc_div_ctl_t;

    // Breakpoint value after reset, by breakpoint number.
    function automatic logic [SAMPLE_W-1:0] bp_reset(input logic [POINT_W-1:0] idx);
        logic [SAMPLE_W-1:0] val;
        unique case (idx)
            2'd0:    val = QUARTER_1;
            2'd1:    val = QUARTER_2;
            2'd2:    val = QUARTER_3;
            default: val = FULL_SCALE;
        endcase
        return val;
    endfunction

endpackage

/* design/apc_if.sv */
// Valid/ready channel interfaces for calibration items and calibrated results.
`timescale 1ns / 1ps

interface apc_in_if;
    import apc_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [CHAN_W-1:0]   channel;
    logic [POINT_W-1:0]  point_index;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] breakpoint_value;

    modport source (
        output valid, mode, channel, point_index, sample, breakpoint_value,
        input  ready
    );

    modport sink (
        input  valid, mode, channel, point_index, sample, breakpoint_value,
        output ready
    );

    modport monitor (
        input valid, ready, mode, channel, point_index, sample, breakpoint_value
    );
endinterface

interface apc_out_if;
    import apc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   out_channel;
    logic [SAMPLE_W-1:0] calibrated;
    logic                changed;

    modport source (
        output valid, out_channel, calibrated, changed,
        input  ready
    );

    modport sink (
        input  valid, out_channel, calibrated, changed,
        output ready
    );

    modport monitor (
        input valid, ready, out_channel, calibrated, changed
    );
endinterface

/* design/apc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module apc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/apc_div.sv */
// Bit-serial restoring divider shared by the ring mean and the segment interpolation.
`timescale 1ns / 1ps

module apc_div #(
    parameter int DIVD_W = 19
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  apc_pkg::apc_div_ctl_t          ctl,
    input  logic [DIVD_W-1:0]              dividend,
    input  logic [apc_pkg::SAMPLE_W-1:0]   rem_init,
    input  logic [apc_pkg::SAMPLE_W-1:0]   divisor,
    output logic                           done,
    output logic [apc_pkg::SAMPLE_W-1:0]   quotient
);
    import apc_pkg::*;

    localparam int STEPS_MAX = (DIVD_W > FRAC_W) ? DIVD_W : FRAC_W;
    localparam int CNT_W     = $clog2(STEPS_MAX + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] dvs_reg;
    logic [DIVD_W-1:0]   shf_reg;
    logic [SAMPLE_W-1:0] q_reg;

    logic [SAMPLE_W:0]   trial;
    logic                fits;
    logic [SAMPLE_W-1:0] rem_next;

    // One quotient bit per cycle: the partial remainder stays below the divisor,
    // so the trial value is never wider than the divisor plus one bit.
    always_comb
    begin
        trial    = {rem_reg, shf_reg[DIVD_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? SAMPLE_W'(trial - {1'b0, dvs_reg}) : trial[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (ctl.kind == DIV_MEAN) ? CNT_W'(DIVD_W) : CNT_W'(FRAC_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dvs_reg <= divisor;
            q_reg   <= '0;
            if (ctl.kind == DIV_MEAN)
            begin
                rem_reg <= '0;
                shf_reg <= dividend;
            end
            else
            begin
                rem_reg <= rem_init;
                shf_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            shf_reg <= {shf_reg[DIVD_W-2:0], 1'b0};
            q_reg   <= {q_reg[SAMPLE_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

/* design/averaged_piecewise_calibration_unit.sv */
// Top level of the averaged piecewise calibration unit: control, per-channel state and datapath.
`timescale 1ns / 1ps

// Sequence: a sample item passes through fetch, the mean division (averaging on only),
// segment selection, the segment division (only when interpolation is needed) and output.
// Throughput: one sample item at a time; the next item is taken once the result is
// registered. Load items are taken while idle and leave the block idle.
// Reset: rst_n is asynchronous and active low; averaging comes up on, rings, sums and last
// outputs read as zero, breakpoints as the quarter points and full scale; no clearing pass.
module averaged_piecewise_calibration_unit #(
    parameter int AVERAGE_DEPTH = 8,
    parameter int CHANNELS      = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [apc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [apc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [apc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    apc_in_if.sink                          item,
    apc_out_if.source                       result
);
    import apc_pkg::*;

    // Derived sizes. The sample ring of a channel occupies a power-of-two row of the history
    // RAM, so its address is simply the channel number above the ring slot.
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HD_W       = $clog2(AVERAGE_DEPTH);
    localparam int SUM_W      = SAMPLE_W + HD_W;
    localparam int SUM_X_W    = SUM_W + 1;
    localparam int HIST_AW    = CH_W + HD_W;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int BP_AW      = CH_W + POINT_W;
    localparam int BP_DEPTH   = 1 << BP_AW;
    localparam int CHAN_CMP_W = CHAN_W + 2;

    // Control state.
    apc_state_t          state_reg;
    apc_state_t          state_next;
    logic                avg_on_reg;
    logic [2:0]          k_reg;
    logic                out_valid_reg;

    // Per-channel state held in flip-flops. A ring is written in slot order from slot zero,
    // so a slot that was never written is exactly one at or above the head while the
    // ring has not yet wrapped: filled_reg marks the wrap and replaces a clearing pass.
    logic [HD_W-1:0]     head_reg   [CHANNELS];
    logic                filled_reg [CHANNELS];
    logic [SUM_W-1:0]    sum_reg    [CHANNELS];
    logic [SAMPLE_W-1:0] last_reg   [CHANNELS];
    logic                bp_valid_reg [BP_DEPTH];

    // Item payload and working values.
    logic [CH_W-1:0]     ch_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] v_reg;
    logic [SAMPLE_W-1:0] bp_reg [POINTS];
    logic                bp_rvalid_reg;
    logic [SAMPLE_W-1:0] base_reg;
    logic [SAMPLE_W-1:0] res_reg;
    logic [CHAN_W-1:0]   out_ch_reg;
    logic [SAMPLE_W-1:0] out_cal_reg;
    logic                out_chg_reg;

    // Handshake and decode.
    logic                item_xfer;
    logic                in_range;
    logic                cfg_write;
    logic                out_load;

    // Memories.
    logic                hist_we;
    logic [HIST_AW-1:0]  hist_addr;
    logic [SAMPLE_W-1:0] hist_rdata;
    logic                bp_we;
    logic [BP_AW-1:0]    bp_waddr;
    logic [BP_AW-1:0]    bp_raddr;
    logic [SAMPLE_W-1:0] bp_rdata;

    // Ring update.
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    sum_new;
    logic [HD_W-1:0]     head_new;
    logic                ring_update;
    logic [POINT_W-1:0]  fill_idx;

    // Segment selection.
    logic                sel_direct;
    logic [SAMPLE_W-1:0] sel_value;
    logic [SAMPLE_W-1:0] seg_lo;
    logic [SAMPLE_W-1:0] seg_span;
    logic [SAMPLE_W-1:0] seg_base;
    logic [SAMPLE_W-1:0] seg_d;

    // Divider.
    apc_div_ctl_t        div_ctl;
    logic [SAMPLE_W-1:0] div_divisor;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_q;

    // ------------------------------------------------------------------
    // Configuration port. The only register is the averaging switch at offset zero;
    // writes to other offsets are dropped and read back as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_AVG_ON);
    assign prdata    = (paddr == ADDR_AVG_ON) ? APB_DATA_W'(avg_on_reg) : '0;

    // ------------------------------------------------------------------
    // Memories: the sample rings of all channels and the breakpoint table.
    // Breakpoints that were never loaded read as their reset value (a quarter point, or
    // full scale for the last) through one valid bit per entry.
    // ------------------------------------------------------------------
    assign hist_addr = {ch_reg, head_reg[ch_reg]};
    assign bp_raddr  = {ch_reg, k_reg[POINT_W-1:0]};
    assign bp_waddr  = {CH_W'(item.channel), item.point_index};

    apc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_addr),
        .wdata (sample_reg),
        .raddr (hist_addr),
        .rdata (hist_rdata)
    );

    apc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BP_DEPTH)
    ) u_bp_ram (
        .clk   (clk),
        .we    (bp_we),
        .waddr (bp_waddr),
        .wdata (item.breakpoint_value),
        .raddr (bp_raddr),
        .rdata (bp_rdata)
    );

    // ------------------------------------------------------------------
    // Ring arithmetic. The oldest slot leaves the running sum as the new sample enters,
    // so the mean needs only one subtract and one add per item.
    // ------------------------------------------------------------------
    always_comb
    begin
        old_sample = filled_reg[ch_reg] ? hist_rdata : '0;
        sum_new    = SUM_W'({1'b0, sum_reg[ch_reg]} + SUM_X_W'(sample_reg)
                            - SUM_X_W'(old_sample));
        head_new   = (head_reg[ch_reg] == HD_W'(AVERAGE_DEPTH - 1)) ? '0
                                                                   : head_reg[ch_reg] + 1'b1;
        fill_idx   = POINT_W'(k_reg - 3'd1);
    end

    // ------------------------------------------------------------------
    // Segment selection. The checks run in a fixed order, so breakpoints that are not
    // ascending still pick a well-defined answer, and a division is only started when
    // the value lies strictly inside a segment, which keeps the span positive and the
    // offset below it.
    // ------------------------------------------------------------------
    always_comb
    begin
        sel_direct = 1'b1;
        sel_value  = '0;
        seg_lo     = '0;
        seg_span   = '0;
        seg_base   = '0;
        if (v_reg == '0)
        begin
            sel_value = '0;
        end
        else if (v_reg < bp_reg[0])
        begin
            sel_direct = 1'b0;
            seg_span   = bp_reg[0];
        end
        else if (v_reg == bp_reg[0])
        begin
            sel_value = QUARTER_1;
        end
        else if (v_reg < bp_reg[1])
        begin
            sel_direct = 1'b0;
            seg_lo     = bp_reg[0];
            seg_span   = bp_reg[1] - bp_reg[0];
            seg_base   = QUARTER_1;
        end
        else if (v_reg == bp_reg[1])
        begin
            sel_value = QUARTER_2;
        end
        else if (v_reg < bp_reg[2])
        begin
            sel_direct = 1'b0;
            seg_lo     = bp_reg[1];
            seg_span   = bp_reg[2] - bp_reg[1];
            seg_base   = QUARTER_2;
        end
        else if (v_reg == bp_reg[2])
        begin
            sel_value = QUARTER_3;
        end
        else if (v_reg < bp_reg[3])
        begin
            sel_direct = 1'b0;
            seg_lo     = bp_reg[2];
            seg_span   = bp_reg[3] - bp_reg[2];
            seg_base   = QUARTER_3;
        end
        else
        begin
            sel_value = FULL_SCALE;
        end
        seg_d = v_reg - seg_lo;
    end

    // ------------------------------------------------------------------
    // Shared bit-serial divider. With averaging on it first forms the ring mean (sum over
    // AVERAGE_DEPTH); when the value lies inside a segment it then forms the segment offset
    // (offset * 16384 over span) with the offset as its starting remainder.
    // ------------------------------------------------------------------
    assign div_divisor = (state_reg == ST_SELECT) ? seg_span : SAMPLE_W'(AVERAGE_DEPTH);

    apc_div #(
        .DIVD_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (sum_new),
        .rem_init (seg_d),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer && in_range && (item.mode == MODE_SAMPLE))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (k_reg == FETCH_LAST)
                begin
                    state_next = avg_on_reg ? ST_MEAN : ST_SELECT;
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                state_next = sel_direct ? ST_OUT : ST_SEG;
            end
            ST_SEG:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. Items are taken only while idle; a finished result
    // waits in the output register, so the next item can enter while it is
    // still pending and only the final hand-over of that item stalls on it.
    // ------------------------------------------------------------------
    always_comb
    begin
        item.ready   = (state_reg == ST_IDLE);
        item_xfer    = item.valid && item.ready;
        in_range     = ({2'b00, item.channel} < CHAN_CMP_W'(CHANNELS));
        bp_we        = item_xfer && in_range && (item.mode == MODE_LOAD);
        ring_update  = (state_reg == ST_FETCH) && (k_reg == 3'd1) && avg_on_reg;
        hist_we      = ring_update;
        out_load     = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);
        div_ctl      = '{start: 1'b0, kind: DIV_MEAN};
        unique case (state_reg)
            ST_FETCH:
            begin
                div_ctl = '{start: ring_update, kind: DIV_MEAN};
            end
            ST_SELECT:
            begin
                div_ctl = '{start: !sel_direct, kind: DIV_SEGMENT};
            end
            default:
            begin
                div_ctl = '{start: 1'b0, kind: DIV_MEAN};
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers and per-channel state.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            avg_on_reg    <= 1'b1;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                head_reg[c]   <= '0;
                filled_reg[c] <= 1'b0;
                sum_reg[c]    <= '0;
                last_reg[c]   <= '0;
            end
            for (int e = 0; e < BP_DEPTH; e++)
            begin
                bp_valid_reg[e] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                avg_on_reg <= pwdata[0];
            end

            if (item_xfer)
            begin
                k_reg <= '0;
            end
            else if (state_reg == ST_FETCH)
            begin
                k_reg <= k_reg + 3'd1;
            end

            if (bp_we)
            begin
                bp_valid_reg[bp_waddr] <= 1'b1;
            end

            // The ring slot read in the first fetch cycle is replaced in the second one.
            if (ring_update)
            begin
                sum_reg[ch_reg]  <= sum_new;
                head_reg[ch_reg] <= head_new;
                if (head_new == '0)
                begin
                    filled_reg[ch_reg] <= 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg    <= 1'b1;
                last_reg[ch_reg] <= res_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            ch_reg     <= CH_W'(item.channel);
            sample_reg <= item.sample;
            v_reg      <= item.sample;
        end

        // Breakpoint reads are issued one per fetch cycle and land in the following cycle.
        bp_rvalid_reg <= bp_valid_reg[bp_raddr];
        if ((state_reg == ST_FETCH) && (k_reg != 3'd0))
        begin
            bp_reg[fill_idx] <= bp_rvalid_reg ? bp_rdata : bp_reset(fill_idx);
        end

        if ((state_reg == ST_MEAN) && div_done)
        begin
            v_reg <= div_q;
        end

        if (state_reg == ST_SELECT)
        begin
            res_reg  <= sel_value;
            base_reg <= seg_base;
        end

        if ((state_reg == ST_SEG) && div_done)
        begin
            res_reg <= base_reg + SAMPLE_W'(div_q[FRAC_W-1:0]);
        end

        if (out_load)
        begin
            out_ch_reg  <= CHAN_W'(ch_reg);
            out_cal_reg <= res_reg;
            out_chg_reg <= (res_reg != last_reg[ch_reg]);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_channel = out_ch_reg;
    assign result.calibrated  = out_cal_reg;
    assign result.changed     = out_chg_reg;
endmodule

/* design/apc_checker.sv */
// Port-level assertions for the averaged piecewise calibration unit and their bind.
`timescale 1ns / 1ps

module apc_checker #(
    parameter int CHANNELS = 8
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         item_mode,
    input logic [apc_pkg::CHAN_W-1:0]   item_channel,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [apc_pkg::CHAN_W-1:0]   result_out_channel
);
    import apc_pkg::*;

    logic item_xfer;
    logic item_live;

    assign item_xfer = item_valid && item_ready;
    assign item_live = ({2'b00, item_channel} < 5'(CHANNELS));

    // A pending result is not withdrawn before it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
        else $error("result withdrawn while stalled");

    // A breakpoint load never produces a result.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item_mode == MODE_LOAD)) |=> !$rose(result_valid))
        else $error("result appeared after a breakpoint load");

    // A sample transfer on a valid channel occupies the block.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item_mode == MODE_SAMPLE) && item_live) |=> !item_ready)
        else $error("block took a new item while a sample was in progress");

    // Results only name channels that exist.
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({2'b00, result_out_channel} < 5'(CHANNELS)))
        else $error("result names a channel outside the configured set");
endmodule

bind averaged_piecewise_calibration_unit apc_checker #(
    .CHANNELS (CHANNELS)
) u_apc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .item_mode          (item.mode),
    .item_channel       (item.channel),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_out_channel (result.out_channel)
);
